// ===== hdl/ofdmpe_pkg.sv =====
package ofdmpe_pkg;

  // Continual pilot base table (8K positions, relative to the first active carrier)
  localparam int unsigned CpCount = 92;
  localparam int unsigned CpIdxW  = 7;

  localparam logic [15:0] CpBase [CpCount] = '{
    16'd44,   16'd122,  16'd203,  16'd262,  16'd346,  16'd410,  16'd490,  16'd559,
    16'd643,  16'd715,  16'd797,  16'd866,  16'd943,  16'd1016, 16'd1094, 16'd1165,
    16'd1247, 16'd1318, 16'd1397, 16'd1469, 16'd1550, 16'd1619, 16'd1700, 16'd1769,
    16'd1850, 16'd1922, 16'd2000, 16'd2069, 16'd2153, 16'd2222, 16'd2299, 16'd2378,
    16'd2453, 16'd2521, 16'd2602, 16'd2678, 16'd2755, 16'd2823, 16'd2900, 16'd2975,
    16'd3053, 16'd3128, 16'd3203, 16'd3278, 16'd3353, 16'd3421, 16'd3500, 16'd3575,
    16'd3650, 16'd3721, 16'd3800, 16'd3878, 16'd3950, 16'd4022, 16'd4097, 16'd4171,
    16'd4250, 16'd4318, 16'd4397, 16'd4469, 16'd4547, 16'd4618, 16'd4694, 16'd4769,
    16'd4844, 16'd4919, 16'd4994, 16'd5065, 16'd5143, 16'd5218, 16'd5294, 16'd5366,
    16'd5441, 16'd5518, 16'd5594, 16'd5669, 16'd5741, 16'd5818, 16'd5893, 16'd5966,
    16'd6044, 16'd6116, 16'd6197, 16'd6262, 16'd6343, 16'd6412, 16'd6493, 16'd6562,
    16'd6643, 16'd6715, 16'd6793, 16'd6869
  };

  // Register indexes on the configuration port
  localparam logic [3:0] CfgFftSize  = 4'd0;
  localparam logic [3:0] CfgPattern  = 4'd1;
  localparam logic [3:0] CfgActive   = 4'd2;
  localparam logic [3:0] CfgFirst    = 4'd3;

  // Pilot kinds
  localparam logic [1:0] KindScattered = 2'd0;
  localparam logic [1:0] KindContinual = 2'd1;
  localparam logic [1:0] KindEdge      = 2'd2;

  // Default active carrier counts per FFT size
  localparam logic [16:0] ActDef8k  = 17'd6913;
  localparam logic [16:0] ActDef16k = 17'd13825;
  localparam logic [16:0] ActDef32k = 17'd27649;

  // Reference sequence generator x^11 + x^2 + 1
  localparam int unsigned LfsrW     = 11;
  localparam int unsigned JumpCount = 16;

  typedef logic [LfsrW-1:0]      lfsr_t;
  typedef lfsr_t [LfsrW-1:0]     lfsr_mat_t;   // column c = image of unit vector c
  typedef lfsr_mat_t [JumpCount-1:0] lfsr_jump_t;

  localparam lfsr_t LfsrSeed = 11'h7FF;

  // Settings derived from the registers
  typedef struct packed {
    logic [14:0] first;
    logic [16:0] last;
    logic [1:0]  fft_sh;    // log2 of FFT size over 8K
    logic [1:0]  dx_sh;     // Dx = 3 << dx_sh
    logic [3:0]  dy_mask;   // Dy - 1
    logic [2:0]  mod_sh;    // Dx * Dy = 3 << mod_sh
  } cfg_t;

  function automatic logic [15:0] cp_base(input logic [CpIdxW-1:0] idx);
    logic [15:0] r;
    r = '1;
    if (idx < CpIdxW'(CpCount)) begin
      r = CpBase[idx];
    end
    return r;
  endfunction

  function automatic lfsr_t lfsr_step(input lfsr_t s);
    return {s[9:0], s[10] ^ s[1]};
  endfunction

  function automatic lfsr_t lfsr_apply(input lfsr_mat_t m, input lfsr_t v);
    lfsr_t r;
    r = '0;
    for (int c = 0; c < LfsrW; c++) begin
      if (v[c]) begin
        r = r ^ m[c];
      end
    end
    return r;
  endfunction

  // Entry b advances the generator by 2**b steps
  function automatic lfsr_jump_t lfsr_jump_table();
    lfsr_jump_t tab;
    lfsr_mat_t  m;
    lfsr_mat_t  sq;
    for (int c = 0; c < LfsrW; c++) begin
      m[c] = lfsr_step(lfsr_t'(1) << c);
    end
    for (int b = 0; b < JumpCount; b++) begin
      tab[b] = m;
      for (int c = 0; c < LfsrW; c++) begin
        sq[c] = lfsr_apply(m, m[c]);
      end
      m = sq;
    end
    return tab;
  endfunction

  function automatic cfg_t cfg_derive(input logic [1:0] code_raw, input logic [3:0] pattern,
                                      input logic [15:0] act_raw, input logic [14:0] first_raw);
    logic [1:0]  code;
    logic [16:0] fft;
    logic [16:0] act;
    logic [16:0] half;
    cfg_t        c;
    code = (code_raw == 2'd3) ? 2'd2 : code_raw;
    fft  = 17'd8192 << code;
    if (act_raw == 16'd0) begin
      case (code)
        2'd0:    act = ActDef8k;
        2'd1:    act = ActDef16k;
        default: act = ActDef32k;
      endcase
    end else begin
      act = {1'b0, act_raw};
    end
    if (act > fft) begin
      act = fft;
    end
    half    = (fft - act) >> 1;
    c.first = (first_raw != 15'd0) ? first_raw : half[14:0];
    c.last  = {2'b00, c.first} + act - 17'd1;
    c.fft_sh = code;
    // Dx / Dy per pattern; unknown patterns fall back to PP1 spacing
    case (pattern)
      4'd2:    begin c.dx_sh = 2'd1; c.dy_mask = 4'd1;  c.mod_sh = 3'd2; end
      4'd3:    begin c.dx_sh = 2'd1; c.dy_mask = 4'd3;  c.mod_sh = 3'd3; end
      4'd4:    begin c.dx_sh = 2'd2; c.dy_mask = 4'd1;  c.mod_sh = 3'd3; end
      4'd5:    begin c.dx_sh = 2'd2; c.dy_mask = 4'd3;  c.mod_sh = 3'd4; end
      4'd6:    begin c.dx_sh = 2'd3; c.dy_mask = 4'd1;  c.mod_sh = 3'd4; end
      4'd7:    begin c.dx_sh = 2'd3; c.dy_mask = 4'd3;  c.mod_sh = 3'd5; end
      4'd8:    begin c.dx_sh = 2'd1; c.dy_mask = 4'd15; c.mod_sh = 3'd5; end
      default: begin c.dx_sh = 2'd0; c.dy_mask = 4'd3;  c.mod_sh = 3'd2; end
    endcase
    return c;
  endfunction

endpackage

// ===== hdl/ofdmpe_cfg.sv =====
module ofdmpe_cfg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [3:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  output ofdmpe_pkg::cfg_t   cfg_o
);

  localparam ofdmpe_pkg::cfg_t CfgReset = ofdmpe_pkg::cfg_derive(2'd0, 4'd1, 16'd0, 15'd0);

  logic [1:0]  fft_code_q;
  logic [3:0]  pattern_q;
  logic [15:0] active_q;
  logic [14:0] first_q;

  ofdmpe_pkg::cfg_t cfg_d;
  ofdmpe_pkg::cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fft_code_q <= 2'd0;
      pattern_q  <= 4'd1;
      active_q   <= 16'd0;
      first_q    <= 15'd0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        ofdmpe_pkg::CfgFftSize: fft_code_q <= cfg_data_i[1:0];
        ofdmpe_pkg::CfgPattern: pattern_q  <= cfg_data_i[3:0];
        ofdmpe_pkg::CfgActive:  active_q   <= cfg_data_i;
        ofdmpe_pkg::CfgFirst:   first_q    <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  // Derived settings, registered behind the registers
  assign cfg_d = ofdmpe_pkg::cfg_derive(fft_code_q, pattern_q, active_q, first_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hdl/ofdmpe_lfsr.sv =====
module ofdmpe_lfsr (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [14:0] bin_i,
  output logic        ref_bit_o
);

  localparam int unsigned Stages  = 4;
  localparam int unsigned BinBits = ofdmpe_pkg::JumpCount;
  localparam int unsigned PerStg  = BinBits / Stages;

  localparam ofdmpe_pkg::lfsr_jump_t JumpTab = ofdmpe_pkg::lfsr_jump_table();

  ofdmpe_pkg::lfsr_t  st_q   [Stages];
  ofdmpe_pkg::lfsr_t  st_d   [Stages];
  ofdmpe_pkg::lfsr_t  stg_in [Stages];
  logic [BinBits-1:0] bin_q  [Stages];
  logic [BinBits-1:0] bin_in [Stages];

  // Jump ahead from the seed: each stage applies the advances for four index bits
  always_comb begin
    stg_in[0] = ofdmpe_pkg::LfsrSeed;
    bin_in[0] = BinBits'(bin_i);
    for (int s = 1; s < Stages; s++) begin
      stg_in[s] = st_q[s-1];
      bin_in[s] = bin_q[s-1];
    end
    for (int s = 0; s < Stages; s++) begin
      st_d[s] = stg_in[s];
      for (int b = 0; b < PerStg; b++) begin
        if (bin_in[s][s*PerStg + b]) begin
          st_d[s] = ofdmpe_pkg::lfsr_apply(JumpTab[s*PerStg + b], st_d[s]);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < Stages; s++) begin
        st_q[s]  <= st_d[s];
        bin_q[s] <= bin_in[s];
      end
    end
  end

  assign ref_bit_o = st_q[Stages-1][0];

endmodule

// ===== hdl/ofdmpe_cp.sv =====
module ofdmpe_cp (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [14:0] bin_i,
  input  logic [14:0] first_i,
  input  logic [1:0]  fft_sh_i,
  output logic        cont_o
);

  localparam int unsigned IdxW = ofdmpe_pkg::CpIdxW;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(ofdmpe_pkg::CpCount - 1);

  // Stage A: offset into the active band and its unscaled position
  logic [14:0] rel_a_d, rel_a_q, q_a_d, q_a_q;
  // Stage B: upper search bits
  logic [IdxW-1:0] idx_b_d, idx_b_q;
  logic            found_b_d, found_b_q;
  logic [14:0]     rel_b_q, q_b_q;
  // Stage C: lower search bits
  logic [IdxW-1:0] idx_c_d, idx_c_q;
  logic            found_c_q;
  logic [14:0]     rel_c_q;
  // Stage D: membership
  logic            cont_d, cont_q;

  logic [IdxW-1:0] cand_b, cand_c;
  logic [15:0]     base, base_nx, base_sc, off, dlt, dlt2, dlt3;
  logic            last, hit;

  always_comb begin
    rel_a_d = bin_i - first_i;
    q_a_d   = rel_a_d >> fft_sh_i;
  end

  // Binary search for the last base entry not above q, three bits here
  always_comb begin
    idx_b_d   = '0;
    cand_b    = '0;
    found_b_d = ofdmpe_pkg::cp_base('0) <= {1'b0, q_a_q};
    for (int k = IdxW - 1; k >= IdxW - 3; k--) begin
      cand_b = idx_b_d | (IdxW'(1) << k);
      if (ofdmpe_pkg::cp_base(cand_b) <= {1'b0, q_a_q}) begin
        idx_b_d = cand_b;
      end
    end
  end

  // Remaining four bits
  always_comb begin
    idx_c_d = idx_b_q;
    cand_c  = '0;
    for (int k = IdxW - 4; k >= 0; k--) begin
      cand_c = idx_c_d | (IdxW'(1) << k);
      if (ofdmpe_pkg::cp_base(cand_c) <= {1'b0, q_b_q}) begin
        idx_c_d = cand_c;
      end
    end
  end

  // Points in a segment sit at base*scale + step*j, j below the scale
  always_comb begin
    base    = ofdmpe_pkg::cp_base(idx_c_q);
    base_nx = ofdmpe_pkg::cp_base(idx_c_q + IdxW'(1));
    base_sc = base << fft_sh_i;
    off     = {1'b0, rel_c_q} - base_sc;
    dlt     = base_nx - base;
    dlt2    = dlt << 1;
    dlt3    = dlt + dlt2;
    last    = idx_c_q == LastIdx;
    hit     = (off == 16'd0) ||
              (!last && (((fft_sh_i != 2'd0) && (off == dlt)) ||
                         ((fft_sh_i == 2'd2) && ((off == dlt2) || (off == dlt3)))));
    cont_d  = found_c_q && hit;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rel_a_q   <= rel_a_d;
      q_a_q     <= q_a_d;
      idx_b_q   <= idx_b_d;
      found_b_q <= found_b_d;
      rel_b_q   <= rel_a_q;
      q_b_q     <= q_a_q;
      idx_c_q   <= idx_c_d;
      found_c_q <= found_b_q;
      rel_c_q   <= rel_b_q;
      cont_q    <= cont_d;
    end
  end

  assign cont_o = cont_q;

endmodule

// ===== hdl/ofdm_pilot_extractor.sv =====
// Channel   Handshake                  Payload
// --------  -------------------------  -------------------------------------------------
// in        in_valid_i / in_ready_o    bin_index, sym_idx, sample_re, sample_im
// out       out_valid_o / out_ready_i  subcarrier, pilot_kind, ref_positive, recv_re/im,
//                                      chan_re/im
// cfg       cfg_valid_i / cfg_ready_o  cfg_index_i (register number), cfg_data_i
//
// One bin per cycle while no result is held. Pilot bins pass the input register, stages
// 2 to 5 and the output register; the depth is set by the reference sequence jump-ahead
// (four bit groups) and continual-pilot table search, each over four register stages.
// Non-pilot bins leave the pipeline without a transfer on the output side.
// A held result stalls every stage at once; in_ready_o drops only then.
// Reset clears the valid bits and the registers (pattern 1, all others 0).
module ofdm_pilot_extractor (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [14:0]        bin_index_i,
  input  logic [15:0]        sym_idx_i,
  input  logic signed [15:0] sample_re_i,
  input  logic signed [15:0] sample_im_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [14:0]        subcarrier_o,
  output logic [1:0]         pilot_kind_o,
  output logic               ref_positive_o,
  output logic signed [15:0] recv_re_o,
  output logic signed [15:0] recv_im_o,
  output logic signed [15:0] chan_re_o,
  output logic signed [15:0] chan_im_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [3:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i
);

  ofdmpe_pkg::cfg_t cfg;

  logic adv;

  // Stage 1: input register
  logic        v1_q;
  logic [14:0] bin1_q;
  logic [15:0] sym1_q;
  logic [15:0] re1_q, im1_q;
  // Stage 2: band position
  logic        v2_q, rng2_q, edge2_q, beyond2_q;
  logic [14:0] rel2_q, bin2_q;
  logic [3:0]  symm2_q;
  logic [15:0] re2_q, im2_q;
  // Stage 3: scattered offset removed
  logic        v3_q, ge3_q, rng3_q, edge3_q, beyond3_q;
  logic [14:0] diff3_q, bin3_q;
  logic [15:0] re3_q, im3_q;
  // Stage 4: period test, power-of-two part and digit sum
  logic        v4_q, zlow4_q, ge4_q, rng4_q, edge4_q, beyond4_q;
  logic [4:0]  dsum4_q;
  logic [14:0] bin4_q;
  logic [15:0] re4_q, im4_q;
  // Stage 5: scattered decision
  logic        v5_q, scat5_q, rng5_q, edge5_q, beyond5_q;
  logic [14:0] bin5_q;
  logic [15:0] re5_q, im5_q;
  // Output register
  logic        out_valid_q;
  logic [14:0] sub_q;
  logic [1:0]  kind_q;
  logic        pos_q;
  logic [15:0] rre_q, rim_q, cre_q, cim_q;

  logic        rng2_d, edge2_d, beyond2_d;
  logic [14:0] rel2_d;
  logic [16:0] bin_x;
  logic [3:0]  symm2_d;
  logic [8:0]  off3;
  logic        ge3_d;
  logic [14:0] diff3_d;
  logic [14:0] lowmask, dsh;
  logic        zlow4_d;
  logic [4:0]  dsum4_d;
  logic [2:0]  dig3;
  logic        scat5_d;
  logic        cont5, ref_bit, pos, pilot;
  logic [1:0]  kind;

  logic        out_valid_d;
  logic [15:0] cre_d, cim_d;

  function automatic logic [15:0] chan_est(input logic [15:0] x, input logic p);
    logic [15:0] r;
    if (x == 16'h8000) begin
      r = p ? 16'h8001 : 16'h7FFF;
    end else begin
      r = p ? x : (16'd0 - x);
    end
    return r;
  endfunction

  ofdmpe_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  ofdmpe_lfsr u_lfsr (
    .clk_i     (clk_i),
    .en_i      (adv),
    .bin_i     (bin1_q),
    .ref_bit_o (ref_bit)
  );

  ofdmpe_cp u_cp (
    .clk_i    (clk_i),
    .en_i     (adv),
    .bin_i    (bin1_q),
    .first_i  (cfg.first),
    .fft_sh_i (cfg.fft_sh),
    .cont_o   (cont5)
  );

  // Whole pipeline moves unless a result is held at the output
  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  // Stage 2 logic: active band, edges, sign forced past the FFT size
  always_comb begin
    bin_x   = {2'b00, bin1_q};
    rng2_d  = (bin1_q >= cfg.first) && (bin_x <= cfg.last);
    edge2_d = (bin1_q == cfg.first) || (bin_x == cfg.last);
    rel2_d  = bin1_q - cfg.first;
    symm2_d = sym1_q[3:0] & cfg.dy_mask;
    case (cfg.fft_sh)
      2'd0:    beyond2_d = |bin1_q[14:13];
      2'd1:    beyond2_d = bin1_q[14];
      default: beyond2_d = 1'b0;
    endcase
  end

  // Stage 3 logic: first scattered carrier of this symbol is (sym mod Dy) * Dx
  always_comb begin
    off3    = ({5'd0, symm2_q} + {4'd0, symm2_q, 1'b0}) << cfg.dx_sh;
    ge3_d   = {6'd0, off3} <= rel2_q;
    diff3_d = rel2_q - {6'd0, off3};
  end

  // Stage 4 logic: period is 3 << mod_sh, so test the low bits, then mod 3 by digits
  always_comb begin
    lowmask = (15'd1 << cfg.mod_sh) - 15'd1;
    zlow4_d = (diff3_q & lowmask) == 15'd0;
    dsh     = diff3_q >> cfg.mod_sh;
    dsum4_d = 5'd0;
    for (int i = 0; i < 7; i++) begin
      dsum4_d = dsum4_d + {3'd0, dsh[2*i +: 2]};
    end
    dsum4_d = dsum4_d + {4'd0, dsh[14]};
  end

  // Stage 5 logic
  always_comb begin
    dig3    = {1'b0, dsum4_q[1:0]} + {1'b0, dsum4_q[3:2]} + {2'b00, dsum4_q[4]};
    scat5_d = rng4_q && ge4_q && zlow4_q && (dig3 inside {3'd0, 3'd3, 3'd6});
  end

  // Output logic: priority scattered, continual, edge
  always_comb begin
    pos   = beyond5_q || ref_bit;
    pilot = scat5_q || (cont5 && rng5_q) || edge5_q;
    if (scat5_q) begin
      kind = ofdmpe_pkg::KindScattered;
    end else if (cont5 && rng5_q) begin
      kind = ofdmpe_pkg::KindContinual;
    end else begin
      kind = ofdmpe_pkg::KindEdge;
    end
    out_valid_d = v5_q && pilot;
    cre_d       = chan_est(re5_q, pos);
    cim_d       = chan_est(im5_q, pos);
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      v5_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      v1_q        <= in_valid_i;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      v4_q        <= v3_q;
      v5_q        <= v4_q;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (adv) begin
      bin1_q    <= bin_index_i;
      sym1_q    <= sym_idx_i;
      re1_q     <= sample_re_i;
      im1_q     <= sample_im_i;

      rng2_q    <= rng2_d;
      edge2_q   <= edge2_d;
      beyond2_q <= beyond2_d;
      rel2_q    <= rel2_d;
      symm2_q   <= symm2_d;
      bin2_q    <= bin1_q;
      re2_q     <= re1_q;
      im2_q     <= im1_q;

      ge3_q     <= ge3_d;
      diff3_q   <= diff3_d;
      rng3_q    <= rng2_q;
      edge3_q   <= edge2_q;
      beyond3_q <= beyond2_q;
      bin3_q    <= bin2_q;
      re3_q     <= re2_q;
      im3_q     <= im2_q;

      zlow4_q   <= zlow4_d;
      dsum4_q   <= dsum4_d;
      ge4_q     <= ge3_q;
      rng4_q    <= rng3_q;
      edge4_q   <= edge3_q;
      beyond4_q <= beyond3_q;
      bin4_q    <= bin3_q;
      re4_q     <= re3_q;
      im4_q     <= im3_q;

      scat5_q   <= scat5_d;
      rng5_q    <= rng4_q;
      edge5_q   <= edge4_q;
      beyond5_q <= beyond4_q;
      bin5_q    <= bin4_q;
      re5_q     <= re4_q;
      im5_q     <= im4_q;

      sub_q     <= bin5_q;
      kind_q    <= kind;
      pos_q     <= pos;
      rre_q     <= re5_q;
      rim_q     <= im5_q;
      cre_q     <= cre_d;
      cim_q     <= cim_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign subcarrier_o   = sub_q;
  assign pilot_kind_o   = kind_q;
  assign ref_positive_o = pos_q;
  assign recv_re_o      = rre_q;
  assign recv_im_o      = rim_q;
  assign chan_re_o      = cre_q;
  assign chan_im_o      = cim_q;

endmodule

// ===== hdl/ofdmpe_checker.sv =====
module ofdmpe_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic [14:0]        bin_index_i,
  input logic [15:0]        sym_idx_i,
  input logic signed [15:0] sample_re_i,
  input logic signed [15:0] sample_im_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [14:0]        subcarrier_o,
  input logic [1:0]         pilot_kind_o,
  input logic               ref_positive_o,
  input logic signed [15:0] recv_re_o,
  input logic signed [15:0] recv_im_o,
  input logic signed [15:0] chan_re_o,
  input logic signed [15:0] chan_im_o,
  input logic               cfg_valid_i,
  input logic               cfg_ready_o,
  input logic [3:0]         cfg_index_i,
  input logic [15:0]        cfg_data_i
);

  // A held result stays until its transfer
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(subcarrier_o) &&
    $stable(chan_re_o))
    else $error("output result dropped or changed while stalled");

  // Input side is only throttled by a held result
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without an output stall");

  // Channel estimate is the received value times the reference sign, clamped
  a_chan_re: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> chan_re_o == ((recv_re_o == 16'sh8000) ?
      (ref_positive_o ? 16'sh8001 : 16'sh7FFF) :
      (ref_positive_o ? recv_re_o : 16'(16'sd0 - recv_re_o))))
    else $error("real channel estimate mismatch");

  a_chan_im: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> chan_im_o == ((recv_im_o == 16'sh8000) ?
      (ref_positive_o ? 16'sh8001 : 16'sh7FFF) :
      (ref_positive_o ? recv_im_o : 16'(16'sd0 - recv_im_o))))
    else $error("imaginary channel estimate mismatch");

endmodule

bind ofdm_pilot_extractor ofdmpe_checker u_ofdmpe_checker (.*);
